@@ rtl/assert_macros.svh @@
// Assertion helpers used by the oscillator core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/mwo_pkg.sv @@
package mwo_pkg;

    typedef enum logic [2:0] {
        WAVE_SILENT   = 3'd0,
        WAVE_SINE     = 3'd1,
        WAVE_SAW      = 3'd2,
        WAVE_TRIANGLE = 3'd3,
        WAVE_SQUARE   = 3'd4,
        WAVE_NOISE    = 3'd5
    } t_waveform;

    // Register select, taken from paddr[2]
    localparam logic REG_WAVEFORM  = 1'b0;
    localparam logic REG_PHASE_INC = 1'b1;

    localparam logic [31:0] LCG_MUL    = 32'd196314165;
    localparam logic [31:0] LCG_ADD    = 32'd907633515;
    localparam logic [31:0] NOISE_SEED = 32'd22222;

    // pi/2 in unsigned Q62
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

endpackage

@@ rtl/multi_waveform_oscillator_core.sv @@
// An accepted item is registered in stage 1 and then in the stage 2 output register.
// Throughput: one item per cycle while the output is not stalled; stage 1 does the phase add, quarter-wave table
// lookup and LCG step, stage 2 the interpolation multiply.
// Items with advance low are taken and dropped without a sample or a state change.
// Synchronous active-low reset: waveform silent, increment 0, phase 0, noise seed
// 22222, pipeline empty. The sine table is constant logic and needs no fill.
`include "assert_macros.svh"

module multi_waveform_oscillator_core #(
    parameter int SINE_ENTRIES = 1024,
    parameter int SAMPLE_BITS  = 16,
    parameter int PHASE_BITS   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [0] advance
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] o_m_axis_tdata,  // [SAMPLE_BITS-1:0] sample
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IdxBits  = $clog2(SINE_ENTRIES);
    localparam int FracBits = PHASE_BITS - IdxBits;
    localparam int OutW     = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int ExtW     = PHASE_BITS + SAMPLE_BITS + 1;
    localparam int ProdW    = SAMPLE_BITS + FracBits + 2;
    localparam logic [SAMPLE_BITS-1:0] FullMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] FullMin = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS:0]   TwoFull = {1'b1, {SAMPLE_BITS{1'b0}}};

    mwo_pkg::t_waveform      r_waveform;
    logic [31:0]             r_phase_inc;
    logic [PHASE_BITS-1:0]   r_phase;
    logic [31:0]             r_noise;
    logic                    r_v1;
    logic                    r_sine1;
    logic [SAMPLE_BITS-1:0]  r_a1;
    logic [SAMPLE_BITS-1:0]  r_b1;
    logic [FracBits-1:0]     r_fr1;
    logic [SAMPLE_BITS-1:0]  r_val1;
    logic                    r_v2;
    logic [SAMPLE_BITS-1:0]  r_sample;

    logic                    cfg_wr;
    logic                    en1;
    logic                    en2;
    logic                    item;
    logic                    noise_step;
    logic                    periodic;
    logic [PHASE_BITS-1:0]   n_phase;
    logic [31:0]             n_noise;
    logic [SAMPLE_BITS-1:0]  n_val1;
    logic [SAMPLE_BITS-1:0]  n_sample;
    logic [SAMPLE_BITS-1:0]  lut_lo;
    logic [SAMPLE_BITS-1:0]  lut_hi;
    logic [ExtW-1:0]         saw_ext;
    logic [ExtW-1:0]         tri_ext;
    logic [SAMPLE_BITS:0]    tri_u;
    logic [SAMPLE_BITS:0]    tri_abs;
    logic [SAMPLE_BITS-1:0]  saw_u;
    logic [SAMPLE_BITS-1:0]  tri_v;
    logic signed [SAMPLE_BITS:0] sine_diff;
    logic signed [ProdW-1:0] sine_prod;
    logic signed [ProdW-1:0] sine_shift;
    logic [SAMPLE_BITS:0]    sine_sum;
    logic                    sine_in_span;

    // Configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            mwo_pkg::REG_PHASE_INC: prdata = r_phase_inc;
            default:                prdata = {29'd0, r_waveform};
        endcase
    end

    // Handshake: stage 2 is the output register
    assign en2             = !r_v2 || i_m_axis_tready;
    assign en1             = !r_v1 || en2;
    assign o_s_axis_tready = en1;
    assign item            = i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tdata[0];
    assign noise_step      = item && (r_waveform == mwo_pkg::WAVE_NOISE);
    assign o_m_axis_tvalid = r_v2;
    assign o_m_axis_tdata  = OutW'(r_sample);

    mwo_sine_lut #(
        .SINE_ENTRIES(SINE_ENTRIES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_sine_lut (
        .i_idx   (r_phase[PHASE_BITS-1 -: IdxBits]),
        .o_val_lo(lut_lo),
        .o_val_hi(lut_hi)
    );

    // Top phase bits as the unsigned ramp of sawtooth and triangle
    assign saw_ext = ({{(SAMPLE_BITS+1){1'b0}}, r_phase} << SAMPLE_BITS) >> PHASE_BITS;
    assign tri_ext = ({{(SAMPLE_BITS+1){1'b0}}, r_phase} << (SAMPLE_BITS + 1)) >> PHASE_BITS;
    assign saw_u   = saw_ext[SAMPLE_BITS-1:0];
    assign tri_u   = tri_ext[SAMPLE_BITS:0];
    assign tri_abs = tri_u[SAMPLE_BITS] ? {1'b0, tri_u[SAMPLE_BITS-1:0]}
                                        : TwoFull - {1'b0, tri_u[SAMPLE_BITS-1:0]};
    // Subtract half scale by flipping the top bit; the peak saturates
    assign tri_v   = (tri_abs == TwoFull) ? FullMax
                   : {~tri_abs[SAMPLE_BITS-1], tri_abs[SAMPLE_BITS-2:0]};

    assign n_noise = r_noise * mwo_pkg::LCG_MUL + mwo_pkg::LCG_ADD;

    always_comb begin
        periodic = 1'b1;
        unique case (r_waveform)
            mwo_pkg::WAVE_SINE:     n_val1 = lut_lo;
            mwo_pkg::WAVE_SAW:      n_val1 = {~saw_u[SAMPLE_BITS-1], saw_u[SAMPLE_BITS-2:0]};
            mwo_pkg::WAVE_TRIANGLE: n_val1 = tri_v;
            mwo_pkg::WAVE_SQUARE:   n_val1 = r_phase[PHASE_BITS-1] ? FullMax : FullMin;
            mwo_pkg::WAVE_NOISE: begin
                n_val1   = {~n_noise[31], n_noise[30 -: SAMPLE_BITS-1]};
                periodic = 1'b0;
            end
            default: begin
                n_val1   = '0;
                periodic = 1'b0;
            end
        endcase
    end

    assign n_phase = r_phase + r_phase_inc[PHASE_BITS-1:0];

    // Stage 2: a + floor((b - a) * frac)
    assign sine_diff  = $signed({r_b1[SAMPLE_BITS-1], r_b1})
                      - $signed({r_a1[SAMPLE_BITS-1], r_a1});
    assign sine_prod  = sine_diff * $signed({1'b0, r_fr1});
    assign sine_shift = sine_prod >>> FracBits;
    assign sine_sum   = {r_a1[SAMPLE_BITS-1], r_a1} + sine_shift[SAMPLE_BITS:0];
    assign n_sample   = r_sine1 ? sine_sum[SAMPLE_BITS-1:0] : r_val1;

    assign sine_in_span =
        ($signed(n_sample) >= $signed(r_a1) && $signed(n_sample) <= $signed(r_b1)) ||
        ($signed(n_sample) <= $signed(r_a1) && $signed(n_sample) >= $signed(r_b1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waveform  <= mwo_pkg::WAVE_SILENT;
            r_phase_inc <= '0;
            r_phase     <= '0;
            r_noise     <= mwo_pkg::NOISE_SEED;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (paddr[2] == mwo_pkg::REG_WAVEFORM) begin
                    r_waveform <= mwo_pkg::t_waveform'(pwdata[2:0]);
                end else begin
                    r_phase_inc <= pwdata;
                end
            end
            // Advance only the state that the selected waveform owns
            if (item && periodic) begin
                r_phase <= n_phase;
            end
            if (noise_step) begin
                r_noise <= n_noise;
            end
            if (en1) begin
                r_v1 <= item;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (item) begin
            r_sine1 <= (r_waveform == mwo_pkg::WAVE_SINE);
            r_a1    <= lut_lo;
            r_b1    <= lut_hi;
            r_fr1   <= r_phase[FracBits-1:0];
            r_val1  <= n_val1;
        end
        if (en2 && r_v1) begin
            r_sample <= n_sample;
        end
    end

    `ASSERT_NEXT(a_noise_hold, i_clk, i_rst_n, !noise_step, $stable(r_noise))
    `ASSERT_NEXT(a_phase_hold, i_clk, i_rst_n, !(item && periodic), $stable(r_phase))
    `ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !r_v1 && i_m_axis_tready, !o_m_axis_tvalid)
    `ASSERT_IMPL(a_sine_span, i_clk, i_rst_n, r_v1 && r_sine1, sine_in_span)

endmodule

@@ rtl/mwo_sine_lut.sv @@
module mwo_sine_lut #(
    parameter int SINE_ENTRIES = 1024,
    parameter int SAMPLE_BITS  = 16
) (
    input  logic [$clog2(SINE_ENTRIES)-1:0] i_idx,
    output logic [SAMPLE_BITS-1:0]          o_val_lo,
    output logic [SAMPLE_BITS-1:0]          o_val_hi
);

    localparam int IdxBits    = $clog2(SINE_ENTRIES);
    localparam int QtrEntries = SINE_ENTRIES / 4;
    localparam logic [63:0] HpQuot = mwo_pkg::HALF_PI_Q62 / SINE_ENTRIES;
    localparam logic [63:0] HpRem  = mwo_pkg::HALF_PI_Q62 % SINE_ENTRIES;
    localparam logic [IdxBits-2:0]     QtrFull = {1'b1, {(IdxBits-2){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] FullMag = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [SAMPLE_BITS-1:0] FullMax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    typedef logic [SAMPLE_BITS-1:0] t_quarter [QtrEntries];

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // Restoring long division, only evaluated while the table is built
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int k = 63; k >= 0; k--) begin
            rem = {rem[63:0], num[k]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[k] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Taylor series on [0, pi/2], Q62 in and out
    function automatic logic [63:0] sin_q62(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] dv;
        x2   = mul_q62(x, x);
        term = x;
        sum  = x;
        for (int n = 1; n < 30; n++) begin
            dv   = 64'((2 * n) * (2 * n + 1));
            term = div_u64(mul_q62(term, x2), dv);
            if (n % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        return sum;
    endfunction

    function automatic t_quarter build_quarter();
        t_quarter    tbl;
        logic [63:0] kq;
        logic [63:0] x;
        logic [63:0] s;
        logic [63:0] mag;
        for (int j = 0; j < QtrEntries; j++) begin
            kq     = 64'(4 * j);
            x      = HpQuot * kq + ((HpRem * kq) >> IdxBits);
            s      = sin_q62(x);
            mag    = (s + (64'd1 << (62 - SAMPLE_BITS))) >> (63 - SAMPLE_BITS);
            tbl[j] = mag[SAMPLE_BITS-1:0];
        end
        return tbl;
    endfunction

    localparam t_quarter QuarterTbl = build_quarter();

    // Full-period entry from the quarter wave; the top entry equals entry zero
    function automatic logic [SAMPLE_BITS-1:0] rom_at(input logic [IdxBits:0] i);
        logic [1:0]             quad;
        logic [IdxBits-3:0]     r;
        logic [IdxBits-2:0]     j;
        logic [SAMPLE_BITS-1:0] mag;
        quad = i[IdxBits-1:IdxBits-2];
        r    = i[IdxBits-3:0];
        j    = quad[0] ? (QtrFull - {1'b0, r}) : {1'b0, r};
        mag  = j[IdxBits-2] ? FullMag : QuarterTbl[j[IdxBits-3:0]];
        if (i[IdxBits]) begin
            return '0;
        end else if (quad[1]) begin
            return ~mag + 1'b1;
        end else if (mag[SAMPLE_BITS-1]) begin
            return FullMax;
        end else begin
            return mag;
        end
    endfunction

    logic [IdxBits:0] idx_lo;
    logic [IdxBits:0] idx_hi;

    assign idx_lo   = {1'b0, i_idx};
    assign idx_hi   = idx_lo + 1'b1;
    assign o_val_lo = rom_at(idx_lo);
    assign o_val_hi = rom_at(idx_hi);

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
    import mwo_pkg::*;

    localparam int          SINE_N         = 1024;
    localparam longint      FULL_SCALE     = 32768;
    localparam int          RANDOM_TICKS   = 950;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          SETTLE_CYCLES  = 4;
    localparam logic [7:0]  TICK           = 8'h01;
    localparam logic [7:0]  NO_TICK        = 8'h00;
    localparam logic [2:0]  WAVE_SPARE_LO  = 3'd6;
    localparam logic [2:0]  WAVE_SPARE_HI  = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;
    logic [31:0] prdata;
    logic        pready;

    multi_waveform_oscillator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    // Oscillator state as the block should hold it
    logic [2:0]  wave_sel = WAVE_SILENT;
    logic [31:0] phase_inc = '0;
    logic [31:0] phase_acc = '0;
    logic [31:0] lcg_state = NOISE_SEED;
    int          sine_table [0:SINE_N];

    logic [7:0]  tick_queue [$];
    logic [15:0] expected_samples [$];
    int unsigned errors = 0;
    int unsigned idle_cycles = 0;
    int unsigned send_gap = 0;
    int unsigned recv_stall = 0;
    bit          no_idle = 1'b0;

    function automatic bit [63:0] mul_q62(input bit [63:0] a, input bit [63:0] b);
        bit [127:0] prod;
        prod = {64'b0, a} * {64'b0, b};
        return prod[125:62];
    endfunction

    function automatic int unsigned idle_draw();
        if (no_idle)
            return 0;
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
    endfunction

    // Build the sine table with a Q62 Taylor series, quarter wave mirrored
    initial begin : build_sine
        bit [63:0] k, kq, x, x2, term, sum, mag, n;
        bit [63:0] half_pi;
        bit        neg;
        half_pi = HALF_PI_Q62;
        for (int i = 0; i <= SINE_N; i++) begin
            k = (4 * i) % (4 * SINE_N);
            neg = 1'b0;
            if (k <= SINE_N) begin
                kq = k;
            end else if (k <= 2 * SINE_N) begin
                kq = 2 * SINE_N - k;
            end else if (k <= 3 * SINE_N) begin
                kq = k - 2 * SINE_N;
                neg = 1'b1;
            end else begin
                kq = 4 * SINE_N - k;
                neg = 1'b1;
            end
            x = (half_pi / SINE_N) * kq + ((half_pi % SINE_N) * kq) / SINE_N;
            x2 = mul_q62(x, x);
            term = x;
            sum = x;
            for (n = 1; n < 30 && term != 0; n++) begin
                term = mul_q62(term, x2) / ((2 * n) * (2 * n + 1));
                if (n[0])
                    sum -= term;
                else
                    sum += term;
            end
            mag = (sum + (64'd1 << 46)) >> 47;
            if (neg)
                sine_table[i] = -int'(mag);
            else if (mag > FULL_SCALE - 1)
                sine_table[i] = int'(FULL_SCALE - 1);
            else
                sine_table[i] = int'(mag);
        end
    end

    // Work out the sample for one accepted item and advance the state
    task automatic predict_sample(input logic [7:0] item);
        longint    v, d, t;
        int        a, b;
        logic [31:0] p;
        bit        periodic;
        if (!item[0])
            return;
        p = phase_acc;
        periodic = 1'b1;
        case (wave_sel)
            WAVE_SINE: begin
                a = sine_table[p[31:22]];
                b = sine_table[p[31:22] + 1];
                t = longint'(b - a) * longint'({p[21:0], 10'b0});
                v = a + (t >>> 32);
            end
            WAVE_SAW: v = longint'(p[31:16]) - FULL_SCALE;
            WAVE_TRIANGLE: begin
                d = longint'(p[31:15]) - 2 * FULL_SCALE;
                if (d < 0)
                    d = -d;
                v = d - FULL_SCALE;
            end
            WAVE_SQUARE: v = p[31] ? FULL_SCALE - 1 : -FULL_SCALE;
            WAVE_NOISE: begin
                lcg_state = lcg_state * LCG_MUL + LCG_ADD;
                v = longint'(lcg_state[31:16]) - FULL_SCALE;
                periodic = 1'b0;
            end
            default: begin
                v = 0;
                periodic = 1'b0;
            end
        endcase
        if (v > FULL_SCALE - 1)
            v = FULL_SCALE - 1;
        if (v < -FULL_SCALE)
            v = -FULL_SCALE;
        if (periodic)
            phase_acc = p + phase_inc;
        expected_samples.push_back(v[15:0]);
    endtask

    // Sender: one item per handshake, random gap after each
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_tvalid && o_s_axis_tready) begin
                predict_sample(s_tdata);
                send_gap = idle_draw();
            end
            if (!s_tvalid || o_s_axis_tready) begin
                if (send_gap != 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (tick_queue.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= tick_queue.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: compare each sample with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end else begin
            if (o_m_axis_tvalid && m_tready) begin
                if (expected_samples.size() == 0) begin
                    $display("%0t: unexpected sample, expected none, got %0d",
                             $time, $signed(o_m_axis_tdata));
                    errors++;
                end else if (o_m_axis_tdata !== expected_samples[0]) begin
                    $display("%0t: sample mismatch, expected %0d, got %0d", $time,
                             $signed(expected_samples[0]), $signed(o_m_axis_tdata));
                    errors++;
                    void'(expected_samples.pop_front());
                end else begin
                    void'(expected_samples.pop_front());
                end
                recv_stall = idle_draw();
            end
            if (recv_stall != 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic reg_write(input logic sel, input logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == REG_WAVEFORM)
            wave_sel = data[2:0];
        else
            phase_inc = data;
        @(negedge i_clk);
    endtask

    // Hold until every sample is back, then let the pipeline settle
    task automatic drain();
        while (tick_queue.size() != 0 || s_tvalid || expected_samples.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) tick_queue.push_back(TICK);
    endtask

    initial begin
        int unsigned random_ticks;
        int unsigned r, n;
        logic [2:0]  code;
        logic [31:0] inc;

        random_ticks = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset state: silent, then the unused codes
        reg_write(REG_PHASE_INC, 32'h4000_0000);
        send_ticks(2);
        tick_queue.push_back(NO_TICK);
        drain();
        reg_write(REG_WAVEFORM, 32'hFFFF_FFFF);
        send_ticks(1);
        drain();
        reg_write(REG_WAVEFORM, 32'(WAVE_SPARE_LO));
        send_ticks(1);
        drain();

        // Sine at the quarter points, a dropped item in between
        reg_write(REG_WAVEFORM, 32'(WAVE_SINE));
        send_ticks(2);
        tick_queue.push_back(NO_TICK);
        send_ticks(2);
        drain();

        reg_write(REG_WAVEFORM, 32'(WAVE_SAW));
        reg_write(REG_PHASE_INC, 32'hFFFF_FFFF);
        send_ticks(2);
        drain();
        reg_write(REG_WAVEFORM, 32'(WAVE_TRIANGLE));
        send_ticks(2);
        drain();
        reg_write(REG_WAVEFORM, 32'(WAVE_SQUARE));
        reg_write(REG_PHASE_INC, 32'h8000_0000);
        send_ticks(2);
        drain();
        reg_write(REG_WAVEFORM, 32'(WAVE_NOISE));
        send_ticks(3);
        drain();
        reg_write(REG_WAVEFORM, 32'(WAVE_SINE));
        reg_write(REG_PHASE_INC, 32'h0000_0001);
        send_ticks(2);
        drain();

        while (random_ticks < RANDOM_TICKS) begin
            no_idle = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 15);
            case (r)
                0: code = WAVE_SILENT;
                1: code = WAVE_SPARE_LO;
                2: code = WAVE_SPARE_HI;
                default: code = WAVE_SINE + 3'(r % 5);
            endcase
            reg_write(REG_WAVEFORM, ($urandom() & ~32'h7) | 32'(code));
            if ($urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 7))
                    0: inc = '0;
                    1: inc = 32'h0000_0001;
                    2: inc = '1;
                    3: inc = 32'h8000_0000;
                    4: inc = $urandom_range(1, 1 << 20);
                    default: inc = $urandom();
                endcase
                reg_write(REG_PHASE_INC, inc);
            end
            n = $urandom_range(20, 80);
            repeat (n) begin
                if ($urandom_range(0, 9) == 0) begin
                    tick_queue.push_back(NO_TICK);
                end else begin
                    tick_queue.push_back(TICK);
                    random_ticks++;
                end
            end
            drain();
        end

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
